### rtl/sliding_window_sender_assert.svh
// Assertion macros shared by the sliding window sender.
// Both sample on clk and are switched off while arst_n is low.
`ifndef SLIDING_WINDOW_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define SWS_ASSERT_SAME(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define SWS_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/swsnd_pkg.sv
`timescale 1ns / 1ps

package swsnd_pkg;

	localparam int CMD_W     = 2;
	localparam int ACK_W     = 3;
	localparam int SEQ_OUT_W = 3;
	localparam int DATA_W    = 64;
	localparam int TIMER_W   = 2;
	localparam int DUP_W     = 2;
	// Wide enough to compare any sequence pointer with an ack number.
	localparam int CMP_W     = 9;
	localparam int ACK_VALUES = 8;

	localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [TIMER_W-1:0] TMR_NONE    = 2'd0;
	localparam logic [TIMER_W-1:0] TMR_START   = 2'd1;
	localparam logic [TIMER_W-1:0] TMR_STOP    = 2'd2;
	localparam logic [TIMER_W-1:0] TMR_RESTART = 2'd3;

	localparam logic [DUP_W-1:0] DUP_TRIGGER = 2'd3;

	typedef struct packed {
		logic               send_accepted;
		logic               transmit;
		logic               is_retransmit;
		logic [TIMER_W-1:0] timer_action;
		logic               ack_advanced;
		logic               window_full;
	} result_flags_t;

endpackage

### rtl/swsnd_store.sv
`timescale 1ns / 1ps

module swsnd_store #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rd_q;
	logic             rd_valid_q;
	logic             byp_q;
	logic [DW-1:0]    byp_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q       <= mem[rd_addr];
		byp_data_q <= wr_data;
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
			byp_q      <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : (rd_valid_q ? rd_q : '0);

endmodule

### rtl/swsnd_ctrl.sv
`timescale 1ns / 1ps

module swsnd_ctrl #(
	parameter int SEQ_SPACE    = 8,
	parameter int WINDOW_SIZE  = 4,
	parameter int PAYLOAD_BITS = 64,
	parameter int PW           = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  logic [swsnd_pkg::CMD_W-1:0]        cmd,
	input  logic [PAYLOAD_BITS-1:0]            payload,
	input  logic [swsnd_pkg::ACK_W-1:0]        ack,
	input  logic                               ack_ok,
	input  logic [PAYLOAD_BITS-1:0]            rd_data,
	output logic                               wr_en,
	output logic [PW-1:0]                      wr_addr,
	output logic [PAYLOAD_BITS-1:0]            wr_data,
	output logic [PW-1:0]                      rd_addr,
	output swsnd_pkg::result_flags_t           flags,
	output logic [swsnd_pkg::SEQ_OUT_W-1:0]    tx_seq,
	output logic [PAYLOAD_BITS-1:0]            tx_data
);

	localparam int WMOD = WINDOW_SIZE % SEQ_SPACE;

	logic [PW-1:0]                     base_q;
	logic [PW-1:0]                     next_q;
	logic [swsnd_pkg::DUP_W-1:0]       dup_q;
	logic [PW-1:0]                     base_nx;
	logic [PW-1:0]                     next_nx;
	logic [swsnd_pkg::DUP_W-1:0]       dup_nx;
	logic [PW-1:0]                     next_inc;
	logic [PW:0]                       end_sum;
	logic [PW-1:0]                     end_now;
	logic [PW:0]                       end_sum_nx;
	logic [PW-1:0]                     end_nx;
	logic                              full_now;
	logic [swsnd_pkg::CMP_W-1:0]       ack_x;
	logic [swsnd_pkg::CMP_W-1:0]       base_x;
	logic [swsnd_pkg::CMP_W-1:0]       end_x;
	logic                              in_win;
	logic [PW-1:0]                     ack_next_tbl [swsnd_pkg::ACK_VALUES];
	logic                              send_ok;
	logic                              xmit;
	logic                              retx;
	logic                              adv;
	logic [swsnd_pkg::TIMER_W-1:0]     timer;
	logic [PW-1:0]                     seq;
	logic [swsnd_pkg::CMP_W-1:0]       seq_x;

	// Base pointer after an ack of k: (k + 1) mod SEQ_SPACE.
	for (genvar k = 0; k < swsnd_pkg::ACK_VALUES; k++) begin : g_ack_next
		assign ack_next_tbl[k] = PW'((k + 1) % SEQ_SPACE);
	end

	assign next_inc = (next_q == PW'(SEQ_SPACE - 1)) ? '0 : next_q + PW'(1);

	// Window end, one compare and subtract since base + WMOD < 2 * SEQ_SPACE.
	assign end_sum  = {1'b0, base_q} + (PW+1)'(WMOD);
	assign end_now  = (end_sum >= (PW+1)'(SEQ_SPACE)) ?
		PW'(end_sum - (PW+1)'(SEQ_SPACE)) : end_sum[PW-1:0];
	assign full_now = (end_now == next_q);

	assign ack_x  = swsnd_pkg::CMP_W'(ack);
	assign base_x = swsnd_pkg::CMP_W'(base_q);
	assign end_x  = swsnd_pkg::CMP_W'(end_now);
	assign in_win = (base_x < end_x) ? (ack_x >= base_x && ack_x < end_x)
	                                 : (ack_x >= base_x || ack_x < end_x);

	always_comb begin
		send_ok = 1'b0;
		xmit    = 1'b0;
		retx    = 1'b0;
		adv     = 1'b0;
		timer   = swsnd_pkg::TMR_NONE;
		seq     = '0;
		tx_data = '0;
		base_nx = base_q;
		next_nx = next_q;
		dup_nx  = dup_q;
		case (cmd)
			swsnd_pkg::CMD_SEND: begin
				if (!full_now) begin
					send_ok = 1'b1;
					xmit    = 1'b1;
					seq     = next_q;
					tx_data = payload;
					next_nx = next_inc;
					if (base_q == next_q) begin
						timer = swsnd_pkg::TMR_START;
					end
				end
			end
			swsnd_pkg::CMD_ACK: begin
				if (ack_ok) begin
					if (in_win) begin
						base_nx = ack_next_tbl[ack];
						dup_nx  = '0;
						adv     = 1'b1;
						timer   = (base_nx != next_q) ? swsnd_pkg::TMR_RESTART
						                              : swsnd_pkg::TMR_STOP;
					end else begin
						dup_nx = dup_q + swsnd_pkg::DUP_W'(1);
						if (dup_nx == swsnd_pkg::DUP_TRIGGER) begin
							xmit    = 1'b1;
							retx    = 1'b1;
							seq     = base_q;
							tx_data = rd_data;
						end
					end
				end
			end
			swsnd_pkg::CMD_TIMEOUT: begin
				xmit    = 1'b1;
				retx    = 1'b1;
				seq     = base_q;
				tx_data = rd_data;
				timer   = swsnd_pkg::TMR_RESTART;
			end
			default: begin
			end
		endcase
	end

	assign end_sum_nx = {1'b0, base_nx} + (PW+1)'(WMOD);
	assign end_nx     = (end_sum_nx >= (PW+1)'(SEQ_SPACE)) ?
		PW'(end_sum_nx - (PW+1)'(SEQ_SPACE)) : end_sum_nx[PW-1:0];

	assign seq_x  = swsnd_pkg::CMP_W'(seq);
	assign tx_seq = seq_x[swsnd_pkg::SEQ_OUT_W-1:0];

	assign flags = '{
		send_accepted: send_ok,
		transmit:      xmit,
		is_retransmit: retx,
		timer_action:  timer,
		ack_advanced:  adv,
		window_full:   (end_nx == next_nx)
	};

	assign wr_en   = fire && send_ok;
	assign wr_addr = next_q;
	assign wr_data = payload;
	// The store is read at the base that the next request will see.
	assign rd_addr = fire ? base_nx : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			next_q <= '0;
			dup_q  <= '0;
		end else if (fire) begin
			base_q <= base_nx;
			next_q <= next_nx;
			dup_q  <= dup_nx;
		end
	end

endmodule

### rtl/sliding_window_sender.sv
`timescale 1ns / 1ps
// Sender side of a cumulative-ack sliding window with fast retransmit.
// Requests come in on the in_valid / in_ready channel: command selects a
// send of payload, an arriving ack (ack_number, ack_checksum_ok) or a timer
// expiry. Every request yields exactly one result on out_valid / out_ready,
// carrying the send status, the packet to transmit if any, the timer action
// and the window state after the request.
// A request passes through the request register and then the result
// register before its result shows on out_valid. Throughput is one request
// per cycle while results are taken, bounded by the single read port of the
// packet store, which is read ahead at the base the next request will see.
// Reset clears the pointers, the duplicate count and the store's valid bits,
// so every stored packet reads as zero until written. No clearing pass is
// needed and requests are taken in the first cycle after reset.
// When the receiver stalls, the result is held, one more request waits in
// the request register, and in_ready drops until the result is taken.
module sliding_window_sender #(
	parameter int SEQ_SPACE    = 8,
	parameter int WINDOW_SIZE  = 4,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [swsnd_pkg::CMD_W-1:0]         command,
	input  logic [swsnd_pkg::DATA_W-1:0]        payload,
	input  logic [swsnd_pkg::ACK_W-1:0]         ack_number,
	input  logic                                ack_checksum_ok,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                send_accepted,
	output logic                                transmit,
	output logic                                is_retransmit,
	output logic [swsnd_pkg::SEQ_OUT_W-1:0]     tx_sequence,
	output logic [swsnd_pkg::DATA_W-1:0]        tx_data,
	output logic [swsnd_pkg::TIMER_W-1:0]       timer_action,
	output logic                                ack_advanced,
	output logic                                window_full
);

`include "sliding_window_sender_assert.svh"

	localparam int PW = $clog2(SEQ_SPACE);

	logic                            valid_s1;
	logic [swsnd_pkg::CMD_W-1:0]     cmd_s1;
	logic [PAYLOAD_BITS-1:0]         payload_s1;
	logic [swsnd_pkg::ACK_W-1:0]     ack_s1;
	logic                            ack_ok_s1;

	logic                            out_valid_q;
	swsnd_pkg::result_flags_t        flags_q;
	logic [swsnd_pkg::SEQ_OUT_W-1:0] tx_seq_q;
	logic [swsnd_pkg::DATA_W-1:0]    tx_data_q;

	logic                            out_take;
	logic                            fire;
	logic                            wr_en;
	logic [PW-1:0]                   wr_addr;
	logic [PAYLOAD_BITS-1:0]         wr_data;
	logic [PW-1:0]                   rd_addr;
	logic [PAYLOAD_BITS-1:0]         rd_data;
	swsnd_pkg::result_flags_t        flags;
	logic [swsnd_pkg::SEQ_OUT_W-1:0] tx_seq;
	logic [PAYLOAD_BITS-1:0]         tx_data_c;

	assign out_take = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_take;
	assign in_ready = !valid_s1 || out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1     <= command;
			payload_s1 <= payload[PAYLOAD_BITS-1:0];
			ack_s1     <= ack_number;
			ack_ok_s1  <= ack_checksum_ok;
		end
	end

	swsnd_store #(
		.DEPTH (SEQ_SPACE),
		.AW    (PW),
		.DW    (PAYLOAD_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	swsnd_ctrl #(
		.SEQ_SPACE    (SEQ_SPACE),
		.WINDOW_SIZE  (WINDOW_SIZE),
		.PAYLOAD_BITS (PAYLOAD_BITS),
		.PW           (PW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.cmd     (cmd_s1),
		.payload (payload_s1),
		.ack     (ack_s1),
		.ack_ok  (ack_ok_s1),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.flags   (flags),
		.tx_seq  (tx_seq),
		.tx_data (tx_data_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_q   <= flags;
			tx_seq_q  <= tx_seq;
			tx_data_q <= swsnd_pkg::DATA_W'(tx_data_c);
		end
	end

	assign out_valid     = out_valid_q;
	assign send_accepted = flags_q.send_accepted;
	assign transmit      = flags_q.transmit;
	assign is_retransmit = flags_q.is_retransmit;
	assign tx_sequence   = tx_seq_q;
	assign tx_data       = tx_data_q;
	assign timer_action  = flags_q.timer_action;
	assign ack_advanced  = flags_q.ack_advanced;
	assign window_full   = flags_q.window_full;

	`SWS_ASSERT_SAME(a_send_is_fresh, out_valid_q && flags_q.send_accepted,
		flags_q.transmit && !flags_q.is_retransmit, "accepted send not a fresh transmit")
	`SWS_ASSERT_SAME(a_advance_timer, out_valid_q && flags_q.ack_advanced,
		!flags_q.transmit && (flags_q.timer_action == swsnd_pkg::TMR_STOP ||
		flags_q.timer_action == swsnd_pkg::TMR_RESTART), "advancing ack with bad timer action")
	`SWS_ASSERT_NEXT(a_timeout_resend, fire && cmd_s1 == swsnd_pkg::CMD_TIMEOUT,
		out_valid_q && flags_q.is_retransmit &&
		flags_q.timer_action == swsnd_pkg::TMR_RESTART, "timeout did not resend base")

endmodule

### verif/sliding_window_sender_checker.sv
`timescale 1ns / 1ps

module sliding_window_sender_checker
	import swsnd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [DATA_W-1:0]    payload,
	input  logic [ACK_W-1:0]     ack_number,
	input  logic                 ack_checksum_ok,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 send_accepted,
	input  logic                 transmit,
	input  logic                 is_retransmit,
	input  logic [SEQ_OUT_W-1:0] tx_sequence,
	input  logic [DATA_W-1:0]    tx_data,
	input  logic [TIMER_W-1:0]   timer_action,
	input  logic                 ack_advanced,
	input  logic                 window_full,
	output int                   mismatches,
	output int                   pending,
	output int                   checked,
	output int                   resends,
	output int                   refused
);

	localparam logic [SEQ_OUT_W-1:0] WINDOW_SPAN = 3'd4;

	typedef struct packed {
		logic                 send_accepted;
		logic                 transmit;
		logic                 is_retransmit;
		logic [SEQ_OUT_W-1:0] tx_sequence;
		logic [DATA_W-1:0]    tx_data;
		logic [TIMER_W-1:0]   timer_action;
		logic                 ack_advanced;
		logic                 window_full;
	} sender_result_t;

	logic [SEQ_OUT_W-1:0] base_seq;
	logic [SEQ_OUT_W-1:0] next_seq;
	logic [DUP_W-1:0]     dup_acks;
	logic [DATA_W-1:0]    sent_packets [ACK_VALUES];
	sender_result_t       expected_results [$];
	int n_errors;
	int n_checked;
	int n_resends;
	int n_refused;

	function automatic logic window_closed();
		logic [SEQ_OUT_W-1:0] limit_seq;
		limit_seq = base_seq + WINDOW_SPAN;
		return next_seq == limit_seq;
	endfunction

	// Applies one request to the tracked sender state and returns its result.
	function automatic sender_result_t predict_sender_step(
		input logic [CMD_W-1:0]  cmd,
		input logic [DATA_W-1:0] data,
		input logic [ACK_W-1:0]  ackn,
		input logic              ok
	);
		sender_result_t r;
		logic [SEQ_OUT_W-1:0] offset;
		r = '0;
		offset = ackn - base_seq;
		case (cmd)
			CMD_SEND: begin
				if (!window_closed()) begin
					sent_packets[next_seq] = data;
					if (base_seq == next_seq)
						r.timer_action = TMR_START;
					r.send_accepted = 1'b1;
					r.transmit = 1'b1;
					r.tx_sequence = next_seq;
					r.tx_data = data;
					next_seq = next_seq + 1'b1;
				end
			end
			CMD_ACK: begin
				if (ok) begin
					// The window may reach past the next sequence number.
					if (offset < WINDOW_SPAN) begin
						base_seq = ackn + 1'b1;
						r.timer_action = (base_seq != next_seq) ? TMR_RESTART : TMR_STOP;
						dup_acks = '0;
						r.ack_advanced = 1'b1;
					end else begin
						dup_acks = dup_acks + 1'b1;
						if (dup_acks == DUP_TRIGGER) begin
							r.transmit = 1'b1;
							r.is_retransmit = 1'b1;
							r.tx_sequence = base_seq;
							r.tx_data = sent_packets[base_seq];
						end
					end
				end
			end
			CMD_TIMEOUT: begin
				r.transmit = 1'b1;
				r.is_retransmit = 1'b1;
				r.tx_sequence = base_seq;
				r.tx_data = sent_packets[base_seq];
				r.timer_action = TMR_RESTART;
			end
			default: begin
			end
		endcase
		r.window_full = window_closed();
		return r;
	endfunction

	function automatic void check_field(
		input string             field,
		input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got
	);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sender_result_t want;
		if (!arst_n) begin
			base_seq = '0;
			next_seq = '0;
			dup_acks = '0;
			for (int i = 0; i < ACK_VALUES; i++)
				sent_packets[i] = '0;
			expected_results.delete();
			n_errors = 0;
			n_checked = 0;
			n_resends = 0;
			n_refused = 0;
		end else begin
			// A result leaves only after its request has passed the request and result
			// registers, so the comparison can safely come before this cycle's prediction.
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					n_errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("send_accepted", want.send_accepted, send_accepted);
					check_field("transmit", want.transmit, transmit);
					check_field("is_retransmit", want.is_retransmit, is_retransmit);
					check_field("tx_sequence", want.tx_sequence, tx_sequence);
					check_field("tx_data", want.tx_data, tx_data);
					check_field("timer_action", want.timer_action, timer_action);
					check_field("ack_advanced", want.ack_advanced, ack_advanced);
					check_field("window_full", want.window_full, window_full);
					n_checked++;
					if (want.is_retransmit)
						n_resends++;
				end
			end
			if (in_valid && in_ready) begin
				want = predict_sender_step(command, payload, ack_number, ack_checksum_ok);
				if (command == CMD_SEND && !want.send_accepted)
					n_refused++;
				expected_results.push_back(want);
			end
		end
		mismatches <= n_errors;
		pending <= expected_results.size();
		checked <= n_checked;
		resends <= n_resends;
		refused <= n_refused;
	end

endmodule

### verif/sliding_window_sender_tb.sv
`timescale 1ns / 1ps

module sliding_window_sender_tb;
	import swsnd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 800;
	localparam int CALM_TAIL       = 100;
	localparam int HOLD_OFF_AT     = 300;
	localparam int LONG_HOLD       = 60;
	localparam int STALL_LIMIT     = 1000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = CMD_SEND;
	logic [DATA_W-1:0]    payload = '0;
	logic [ACK_W-1:0]     ack_number = '0;
	logic                 ack_checksum_ok = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 send_accepted;
	logic                 transmit;
	logic                 is_retransmit;
	logic [SEQ_OUT_W-1:0] tx_sequence;
	logic [DATA_W-1:0]    tx_data;
	logic [TIMER_W-1:0]   timer_action;
	logic                 ack_advanced;
	logic                 window_full;

	int mismatches;
	int pending;
	int checked;
	int resends;
	int refused;
	int requests_sent = 0;
	int cycles = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	bit hold_off_due = 1'b0;
	bit hold_off_done = 1'b0;

	sliding_window_sender uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .payload(payload),
		.ack_number(ack_number), .ack_checksum_ok(ack_checksum_ok),
		.out_valid(out_valid), .out_ready(out_ready),
		.send_accepted(send_accepted), .transmit(transmit),
		.is_retransmit(is_retransmit), .tx_sequence(tx_sequence),
		.tx_data(tx_data), .timer_action(timer_action),
		.ack_advanced(ack_advanced), .window_full(window_full)
	);

	sliding_window_sender_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .payload(payload),
		.ack_number(ack_number), .ack_checksum_ok(ack_checksum_ok),
		.out_valid(out_valid), .out_ready(out_ready),
		.send_accepted(send_accepted), .transmit(transmit),
		.is_retransmit(is_retransmit), .tx_sequence(tx_sequence),
		.tx_data(tx_data), .timer_action(timer_action),
		.ack_advanced(ack_advanced), .window_full(window_full),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.resends(resends), .refused(refused)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Offers one request, holds it until taken, then sometimes pauses.
	task automatic issue_request(
		input logic [CMD_W-1:0]  cmd,
		input logic [DATA_W-1:0] data,
		input logic [ACK_W-1:0]  ackn,
		input logic              ok
	);
		in_valid <= 1'b1;
		command <= cmd;
		payload <= data;
		ack_number <= ackn;
		ack_checksum_ok <= ok;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
		if (!calm && (requests_sent / 40) % 3 != 2 && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	initial begin : receiver
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_due && !hold_off_done) begin
				// Long stall so the sender backs up and in_ready drops.
				hold_off_done = 1'b1;
				out_ready <= 1'b0;
				hold = 0;
				while (hold < LONG_HOLD) begin
					@(posedge clk);
					hold++;
				end
			end else if (!calm && (cycles / 64) % 3 != 2 && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3))
					@(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("sliding_window_sender: mismatch");
		$finish;
	end

	initial begin : stimulus
		int counted;
		int pick;
		logic [CMD_W-1:0] cmd;
		logic ok;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: fill the window, refuse a send, walk the duplicate
		// count through its wrap, and move the base in several ways.
		issue_request(CMD_TIMEOUT, {$urandom, $urandom}, 3'd0, 1'b1);
		issue_request(CMD_SEND, 64'h0, 3'd0, 1'b0);
		issue_request(CMD_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1);
		issue_request(CMD_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 1'b0);
		issue_request(CMD_SEND, 64'h5555_5555_5555_5555, 3'd7, 1'b1);
		issue_request(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd0, 1'b0);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd7, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd4, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd5, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd6, 1'b1);
		issue_request(CMD_TIMEOUT, {$urandom, $urandom}, 3'd7, 1'b0);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd1, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd3, 1'b1);
		issue_request(CMD_TIMEOUT, {$urandom, $urandom}, 3'd0, 1'b1);
		issue_request(CMD_UNUSED, {$urandom, $urandom}, 3'd7, 1'b1);
		issue_request(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0);
		issue_request(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd6, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd0, 1'b1);
		issue_request(CMD_SEND, {$urandom, $urandom}, 3'd2, 1'b0);
		issue_request(CMD_SEND, {$urandom, $urandom}, 3'd5, 1'b1);
		issue_request(CMD_ACK, {$urandom, $urandom}, 3'd7, 1'b1);
		issue_request(CMD_TIMEOUT, {$urandom, $urandom}, 3'd2, 1'b0);

		// Random part: stretches heavy in sends alternate with stretches heavy
		// in acks so the window both fills up and drains.
		counted = 0;
		while (counted < RANDOM_REQUESTS) begin
			calm = (counted >= RANDOM_REQUESTS - CALM_TAIL);
			if (counted >= HOLD_OFF_AT)
				hold_off_due = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < (((counted / 20) % 2 == 0) ? 60 : 25))
				cmd = CMD_SEND;
			else if (pick < 88)
				cmd = CMD_ACK;
			else if (pick < 96)
				cmd = CMD_TIMEOUT;
			else
				cmd = CMD_UNUSED;
			ok = ($urandom_range(0, 9) != 0);
			issue_request(cmd, {$urandom, $urandom}, ACK_W'($urandom_range(0, 7)), ok);
			if (cmd != CMD_UNUSED && !(cmd == CMD_ACK && !ok))
				counted++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		$display("Ran %0d requests and checked %0d results.", requests_sent, checked);
		$display("Saw %0d resends and %0d sends refused on a full window.", resends, refused);
		if (mismatches == 0 && pending == 0)
			$display("sliding_window_sender: match");
		else
			$display("sliding_window_sender: mismatch");
		$finish;
	end

endmodule
